// ===== src/hsvrgb_pkg.sv =====
// hsv to rgb converter: shared widths, sector codes and the divide-by-255 helper
// no dependencies
package hsvrgb_pkg;

  localparam int HUE_W  = 11;
  localparam int CH_W   = 8;
  localparam int SEC_W  = 3;
  localparam int LVL_W  = 16;
  localparam int NUM_W  = 24;

  localparam logic [LVL_W-1:0] SECTOR_SCALE = 16'd65280;
  localparam logic [CH_W-1:0]  CH_MAX       = 8'd255;
  localparam logic [CH_W:0]    FRAC_ONE     = 9'd256;

  localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SEC_W-1:0] SECTOR_5 = 3'd5;

  // floor(x / 255) for x up to 65279, so that the result fits in 8 bits
  function automatic logic [CH_W-1:0] div255(input logic [LVL_W-1:0] x);
    logic [LVL_W:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[LVL_W-1:CH_W]};
    return s[LVL_W-1:CH_W];
  endfunction

endpackage

// ===== src/hsv_to_rgb_converter_unit.sv =====
// hsv to rgb converter, three register stages, one pixel per clock when not stalled
// an accepted input beat passes through stage 1, stage 2 and the output register in turn
// one beat per cycle while out_stall does not hold the pipeline
// each stage holds its beat while the next is full and stalled; bubbles collapse
// reset: synchronous, clears all stage valid bits; payload registers are not reset
// depends on hsvrgb_pkg
module hsv_to_rgb_converter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [hsvrgb_pkg::HUE_W-1:0]       hue,
  input  logic [hsvrgb_pkg::CH_W-1:0]        saturation,
  input  logic [hsvrgb_pkg::CH_W-1:0]        brightness,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hsvrgb_pkg::CH_W-1:0]        red,
  output logic [hsvrgb_pkg::CH_W-1:0]        green,
  output logic [hsvrgb_pkg::CH_W-1:0]        blue
);

  logic en1, en2, en3;
  logic v1, v2;

  // stage 1 registers
  logic [hsvrgb_pkg::SEC_W-1:0] sec1;
  logic [hsvrgb_pkg::CH_W-1:0]  bri1;
  logic [hsvrgb_pkg::CH_W-1:0]  keep_p1;
  logic [hsvrgb_pkg::LVL_W-1:0] prod_q1;
  logic [hsvrgb_pkg::LVL_W-1:0] prod_t1;

  // stage 2 registers
  logic [hsvrgb_pkg::SEC_W-1:0] sec2;
  logic [hsvrgb_pkg::CH_W-1:0]  bri2;
  logic [hsvrgb_pkg::LVL_W-1:0] num_p2;
  logic [hsvrgb_pkg::NUM_W-1:0] num_q2;
  logic [hsvrgb_pkg::NUM_W-1:0] num_t2;

  logic [hsvrgb_pkg::CH_W-1:0]  frac;
  logic [hsvrgb_pkg::CH_W:0]    frac_inv;
  logic [hsvrgb_pkg::LVL_W-1:0] prod_t_full;
  logic [hsvrgb_pkg::LVL_W-1:0] keep_q, keep_t;
  logic [hsvrgb_pkg::CH_W-1:0]  lv_p, lv_q, lv_t;
  logic [hsvrgb_pkg::CH_W-1:0]  red_next, green_next, blue_next;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  assign frac        = hue[hsvrgb_pkg::CH_W-1:0];
  assign frac_inv    = hsvrgb_pkg::FRAC_ONE - {1'b0, frac};
  assign prod_t_full = {7'd0, frac_inv} * {8'd0, saturation};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      sec1    <= hue[hsvrgb_pkg::HUE_W-1:hsvrgb_pkg::CH_W];
      bri1    <= brightness;
      keep_p1 <= hsvrgb_pkg::CH_MAX - saturation;
      prod_q1 <= {8'd0, frac} * {8'd0, saturation};
      prod_t1 <= prod_t_full;
    end
  end

  assign keep_q = hsvrgb_pkg::SECTOR_SCALE - prod_q1;
  assign keep_t = hsvrgb_pkg::SECTOR_SCALE - prod_t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      sec2   <= sec1;
      bri2   <= bri1;
      num_p2 <= {8'd0, bri1} * {8'd0, keep_p1};
      num_q2 <= {16'd0, bri1} * {8'd0, keep_q};
      num_t2 <= {16'd0, bri1} * {8'd0, keep_t};
    end
  end

  assign lv_p = hsvrgb_pkg::div255(num_p2);
  assign lv_q = hsvrgb_pkg::div255(num_q2[hsvrgb_pkg::NUM_W-1:hsvrgb_pkg::CH_W]);
  assign lv_t = hsvrgb_pkg::div255(num_t2[hsvrgb_pkg::NUM_W-1:hsvrgb_pkg::CH_W]);

  always_comb begin
    case (sec2)
      hsvrgb_pkg::SECTOR_1: begin
        red_next = lv_q;  green_next = bri2; blue_next = lv_p;
      end
      hsvrgb_pkg::SECTOR_2: begin
        red_next = lv_p;  green_next = bri2; blue_next = lv_t;
      end
      hsvrgb_pkg::SECTOR_3: begin
        red_next = lv_p;  green_next = lv_q; blue_next = bri2;
      end
      hsvrgb_pkg::SECTOR_4: begin
        red_next = lv_t;  green_next = lv_p; blue_next = bri2;
      end
      hsvrgb_pkg::SECTOR_5: begin
        red_next = bri2;  green_next = lv_p; blue_next = lv_q;
      end
      default: begin
        red_next = bri2;  green_next = lv_t; blue_next = lv_p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule
